// ----- rtl/hand_dwell_gesture_detector_core_assert.svh -----
// Assertion macros for the hand dwell gesture detector.
// No dependencies; included by the port checker.
`ifndef HAND_DWELL_GESTURE_DETECTOR_CORE_ASSERT_SVH
`define HAND_DWELL_GESTURE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define HDG_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define HDG_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/hdg_pkg.sv -----
// Shared types and constants of the hand dwell gesture detector.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hdg_pkg;

   localparam int TRAIL_LEN  = 20;
   localparam int HEAD_W     = $clog2(TRAIL_LEN);
   localparam int FILL_W     = $clog2(TRAIL_LEN + 1);
   localparam int POS_W      = $clog2(2 * TRAIL_LEN);

   localparam int COL_W      = 10;
   localparam int ROW_W      = 9;
   localparam int DEPTH_W    = 13;
   localparam int DIST_W     = 23;
   localparam int HOLD_FR_W  = 8;
   localparam int HOLD_W     = 10;
   localparam int SQC_W      = 2 * COL_W;
   localparam int SQR_W      = 2 * ROW_W;
   // 9*dc^2 + 16*dr^2 fits in 2*COL_W + 5 bits
   localparam int SUM_W      = 2 * COL_W + 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 23;

   localparam logic [CSR_IDX_W-1:0] CSR_DIST_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_FRAMES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_ROWS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_COLS   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_COLS  = 3'd4;

   localparam logic [1:0] GEST_NONE      = 2'd0;
   localparam logic [1:0] GEST_TOP_LEFT  = 2'd1;
   localparam logic [1:0] GEST_TOP_RIGHT = 2'd2;

   localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

   typedef struct packed {
      logic [DIST_W-1:0]    dist_limit;
      logic [HOLD_FR_W-1:0] hold_frames;
      logic [ROW_W-1:0]     top_rows;
      logic [COL_W-1:0]     left_cols;
      logic [COL_W-1:0]     right_cols;
   } hdg_cfg_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } hdg_point_type;

   typedef struct packed {
      hdg_point_type lhand;
      hdg_point_type rhand;
   } hdg_entry_type;

   typedef struct packed {
      logic b_load;
      logic out_load;
   } hdg_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/hand_dwell_gesture_detector_core.sv -----
// An accepted request beat passes through stage A (trail read), stage B (squares) and the
// response register (hold update) to its response beat. Throughput: one frame per cycle
// unless rsp_ready stalls; the trail memory is read and written once per frame.
// Reset: synchronous, active high; clears the trail fill and head, hold counters and
// stage valids, and reloads the configuration defaults. Trail contents need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module hand_dwell_gesture_detector_core (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_ready,
   input  wire [hdg_pkg::COL_W-1:0]      req_spine_col,
   input  wire [hdg_pkg::ROW_W-1:0]      req_spine_row,
   input  wire [hdg_pkg::DEPTH_W-1:0]    req_spine_depth,
   input  wire [hdg_pkg::COL_W-1:0]      req_lhand_col,
   input  wire [hdg_pkg::ROW_W-1:0]      req_lhand_row,
   input  wire [hdg_pkg::DEPTH_W-1:0]    req_lhand_depth,
   input  wire [hdg_pkg::COL_W-1:0]      req_rhand_col,
   input  wire [hdg_pkg::ROW_W-1:0]      req_rhand_row,
   input  wire [hdg_pkg::DEPTH_W-1:0]    req_rhand_depth,
   output logic                          rsp_valid,
   input  wire                           rsp_ready,
   output logic                          rsp_left_in_range,
   output logic                          rsp_right_in_range,
   output logic [1:0]                    rsp_left_gesture,
   output logic [1:0]                    rsp_right_gesture,
   input  wire                           csr_we,
   input  wire [hdg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [hdg_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import hdg_pkg::*;

   hdg_cfg_type   cfg_ff;
   hdg_entry_type trail_mem [TRAIL_LEN];
   hdg_entry_type rd_ff, wr_entry;
   hdg_entry_type a_cur_ff;
   hdg_point_type l_old, r_old;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [HEAD_W-1:0] head_ff, head_in, slot, slot_adv;
   logic [POS_W-1:0]  pos;
   logic              full;
   logic              accept;
   logic              l_in, r_in;
   logic              a_v_ff, a_first_ff, a_lin_ff, a_rin_ff;
   logic              b_v_ff, b_free, a_free;
   logic              rsp_valid_ff;
   hdg_ctl_type       ctl;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dist_limit  <= DIST_W'(1474);
         cfg_ff.hold_frames <= HOLD_FR_W'(30);
         cfg_ff.top_rows    <= ROW_W'(48);
         cfg_ff.left_cols   <= COL_W'(64);
         cfg_ff.right_cols  <= COL_W'(576);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIST_LIMIT:  cfg_ff.dist_limit  <= csr_wdata[DIST_W-1:0];
            CSR_HOLD_FRAMES: cfg_ff.hold_frames <= csr_wdata[HOLD_FR_W-1:0];
            CSR_TOP_ROWS:    cfg_ff.top_rows    <= csr_wdata[ROW_W-1:0];
            CSR_LEFT_COLS:   cfg_ff.left_cols   <= csr_wdata[COL_W-1:0];
            CSR_RIGHT_COLS:  cfg_ff.right_cols  <= csr_wdata[COL_W-1:0];
            default: ;
         endcase
      end
   end

   // stage flow: each stage loads when the one after it is free or moving
   always_comb begin
      ctl.out_load = b_v_ff && (!rsp_valid_ff || rsp_ready);
      b_free       = !b_v_ff || ctl.out_load;
      ctl.b_load   = a_v_ff && b_free;
      a_free       = !a_v_ff || ctl.b_load;
      req_ready    = a_free;
      accept       = req_valid && a_free;
   end

   // trail ring addressing; both hands share fill and head
   always_comb begin
      full     = (fill_ff == FILL_W'(TRAIL_LEN));
      pos      = POS_W'(head_ff) + POS_W'(fill_ff);
      if (full) begin
         slot = head_ff;
      end else if (pos >= POS_W'(TRAIL_LEN)) begin
         slot = HEAD_W'(pos - POS_W'(TRAIL_LEN));
      end else begin
         slot = HEAD_W'(pos);
      end
      slot_adv = (slot == HEAD_W'(TRAIL_LEN - 1)) ? '0 : slot + 1'b1;
      head_in  = full ? slot_adv : head_ff;
      fill_in  = full ? fill_ff : fill_ff + 1'b1;
      l_in     = (req_lhand_row < req_spine_row) && (req_lhand_depth < req_spine_depth);
      r_in     = (req_rhand_row < req_spine_row) && (req_rhand_depth < req_spine_depth);
      wr_entry.lhand.col = req_lhand_col;
      wr_entry.lhand.row = req_lhand_row;
      wr_entry.rhand.col = req_rhand_col;
      wr_entry.rhand.row = req_rhand_row;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         head_ff <= '0;
      end else if (accept) begin
         fill_ff <= fill_in;
         head_ff <= head_in;
      end
   end

   // write the new point and read the oldest; the addresses differ except on the
   // first frame, where the current point stands in for the read
   always_ff @(posedge clock) begin
      if (accept) begin
         trail_mem[slot] <= wr_entry;
         rd_ff           <= trail_mem[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_cur_ff   <= wr_entry;
         a_first_ff <= (fill_ff == '0);
         a_lin_ff   <= l_in;
         a_rin_ff   <= r_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff       <= 1'b0;
         b_v_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (a_free) begin
            a_v_ff <= accept;
         end
         if (b_free) begin
            b_v_ff <= ctl.b_load;
         end
         if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_ff <= ctl.out_load;
         end
      end
   end

   always_comb begin
      l_old = a_first_ff ? a_cur_ff.lhand : rd_ff.lhand;
      r_old = a_first_ff ? a_cur_ff.rhand : rd_ff.rhand;
   end

   hdg_hand u_left (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .cfg          (cfg_ff),
      .cur          (a_cur_ff.lhand),
      .old          (l_old),
      .in_range     (a_lin_ff),
      .rsp_in_range (rsp_left_in_range),
      .rsp_gesture  (rsp_left_gesture)
   );

   hdg_hand u_right (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .cfg          (cfg_ff),
      .cur          (a_cur_ff.rhand),
      .old          (r_old),
      .in_range     (a_rin_ff),
      .rsp_in_range (rsp_right_in_range),
      .rsp_gesture  (rsp_right_gesture)
   );

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// ----- rtl/hdg_hand.sv -----
// One hand lane: distance squares, hold counter and corner gesture decode.
// Depends on hdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hdg_hand (
   input  wire                   clock,
   input  wire                   reset,
   input  hdg_pkg::hdg_ctl_type  ctl,
   input  hdg_pkg::hdg_cfg_type  cfg,
   input  hdg_pkg::hdg_point_type cur,
   input  hdg_pkg::hdg_point_type old,
   input  wire                   in_range,
   output logic                  rsp_in_range,
   output logic [1:0]            rsp_gesture
);
   import hdg_pkg::*;

   logic [COL_W-1:0]  dc;
   logic [ROW_W-1:0]  dr;
   logic [SQC_W-1:0]  sqc_in, sqc_ff;
   logic [SQR_W-1:0]  sqr_in, sqr_ff;
   hdg_point_type     pt_ff;
   logic              in_ff;
   logic [SUM_W-1:0]  span;
   logic [HOLD_W-1:0] hold_ff, hold_in;
   logic [1:0]        gesture_in;

   always_comb begin
      dc     = (cur.col > old.col) ? cur.col - old.col : old.col - cur.col;
      dr     = (cur.row > old.row) ? cur.row - old.row : old.row - cur.row;
      sqc_in = SQC_W'(dc) * SQC_W'(dc);
      sqr_in = SQR_W'(dr) * SQR_W'(dr);
   end

   always_ff @(posedge clock) begin
      if (ctl.b_load) begin
         sqc_ff <= sqc_in;
         sqr_ff <= sqr_in;
         pt_ff  <= cur;
         in_ff  <= in_range;
      end
   end

   always_comb begin
      span = (SUM_W'(sqc_ff) << 3) + SUM_W'(sqc_ff) + (SUM_W'(sqr_ff) << 4);
      if (!in_ff) begin
         hold_in = '0;
      end else if (span <= SUM_W'(cfg.dist_limit)) begin
         hold_in = (hold_ff == HOLD_MAX) ? hold_ff : hold_ff + 1'b1;
      end else begin
         hold_in = '0;
      end
      gesture_in = GEST_NONE;
      if (in_ff && hold_in > HOLD_W'(cfg.hold_frames) && pt_ff.row < cfg.top_rows) begin
         // top-left wins when both corners overlap
         if (pt_ff.col < cfg.left_cols) begin
            gesture_in = GEST_TOP_LEFT;
         end else if (pt_ff.col > cfg.right_cols) begin
            gesture_in = GEST_TOP_RIGHT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= '0;
      end else if (ctl.out_load) begin
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.out_load) begin
         rsp_in_range <= in_ff;
         rsp_gesture  <= gesture_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/hdg_checker.sv -----
// Port-level checks of the hand dwell gesture detector, bound to the top level.
// Depends on hdg_pkg and hand_dwell_gesture_detector_core_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "hand_dwell_gesture_detector_core_assert.svh"

module hdg_checker (
   input wire       clock,
   input wire       reset,
   input wire       rsp_valid,
   input wire       rsp_ready,
   input wire       rsp_left_in_range,
   input wire       rsp_right_in_range,
   input wire [1:0] rsp_left_gesture,
   input wire [1:0] rsp_right_gesture
);
   import hdg_pkg::*;

   logic       rsp_stall;
   logic [5:0] rsp_bits;
   logic       left_hit, right_hit, left_ok, right_ok;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_bits  = {rsp_left_in_range, rsp_right_in_range,
                       rsp_left_gesture, rsp_right_gesture};
   assign left_hit  = (rsp_left_gesture != GEST_NONE);
   assign right_hit = (rsp_right_gesture != GEST_NONE);
   assign left_ok   = rsp_left_in_range &&
                      (rsp_left_gesture == GEST_TOP_LEFT || rsp_left_gesture == GEST_TOP_RIGHT);
   assign right_ok  = rsp_right_in_range &&
                      (rsp_right_gesture == GEST_TOP_LEFT || rsp_right_gesture == GEST_TOP_RIGHT);

   // a stalled response beat holds
   `HDG_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_bits), "stalled response changed")

   // a gesture is only reported for a hand in range
   `HDG_ASSERT_IMP(a_left_gest, clock, reset, rsp_valid && left_hit, left_ok, "left gesture without range")
   `HDG_ASSERT_IMP(a_right_gest, clock, reset, rsp_valid && right_hit, right_ok, "right gesture without range")

   // nothing comes out the cycle after reset
   `HDG_ASSERT_IMP(a_reset_quiet, clock, 1'b0, $past(reset), !rsp_valid, "response right after reset")

endmodule

bind hand_dwell_gesture_detector_core hdg_checker u_hdg_checker (.*);

`default_nettype wire

// ----- tb/sv/hdg_frame_checker.sv -----
// Checker for the hand dwell gesture detector: mirrors the register writes, predicts every
// response beat from the accepted request beats and compares field by field.
// Depends on hdg_pkg.
`timescale 1ns / 1ps

module hdg_frame_checker (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   input  wire                           req_ready,
   input  wire [hdg_pkg::COL_W-1:0]      req_spine_col,
   input  wire [hdg_pkg::ROW_W-1:0]      req_spine_row,
   input  wire [hdg_pkg::DEPTH_W-1:0]    req_spine_depth,
   input  wire [hdg_pkg::COL_W-1:0]      req_lhand_col,
   input  wire [hdg_pkg::ROW_W-1:0]      req_lhand_row,
   input  wire [hdg_pkg::DEPTH_W-1:0]    req_lhand_depth,
   input  wire [hdg_pkg::COL_W-1:0]      req_rhand_col,
   input  wire [hdg_pkg::ROW_W-1:0]      req_rhand_row,
   input  wire [hdg_pkg::DEPTH_W-1:0]    req_rhand_depth,
   input  wire                           rsp_valid,
   input  wire                           rsp_ready,
   input  wire                           rsp_left_in_range,
   input  wire                           rsp_right_in_range,
   input  wire [1:0]                     rsp_left_gesture,
   input  wire [1:0]                     rsp_right_gesture,
   input  wire                           csr_we,
   input  wire [hdg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [hdg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                            mismatches,
   output int                            outstanding
);

   import hdg_pkg::*;

   typedef struct packed {
      logic       left_in_range;
      logic       right_in_range;
      logic [1:0] left_gesture;
      logic [1:0] right_gesture;
   } frame_verdict_type;

   localparam int LEFT  = 0;
   localparam int RIGHT = 1;

   // per-hand trail of the last TRAIL_LEN points, oldest at trail_head
   logic [COL_W-1:0] trail_col [2][TRAIL_LEN];
   logic [ROW_W-1:0] trail_row [2][TRAIL_LEN];
   int unsigned      trail_fill [2];
   int unsigned      trail_head [2];
   int unsigned      hold_count [2];

   hdg_cfg_type       cfg;
   frame_verdict_type awaited_verdicts [$];

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Push the point, update the hold counter and return the corner code.
   task automatic advance_trail(input int h, input logic [COL_W-1:0] col,
                                input logic [ROW_W-1:0] row, input logic in_range,
                                output logic [1:0] code);
      int unsigned slot, oldest, dc, dr, span;
      if (trail_fill[h] < TRAIL_LEN) begin
         slot = (trail_head[h] + trail_fill[h]) % TRAIL_LEN;
         trail_fill[h]++;
      end else begin
         slot = trail_head[h];
         trail_head[h] = (slot + 1) % TRAIL_LEN;
      end
      trail_col[h][slot] = col;
      trail_row[h][slot] = row;
      code = GEST_NONE;
      if (!in_range) begin
         hold_count[h] = 0;
      end else begin
         oldest = trail_head[h];
         dc = (col > trail_col[h][oldest]) ? col - trail_col[h][oldest]
                                           : trail_col[h][oldest] - col;
         dr = (row > trail_row[h][oldest]) ? row - trail_row[h][oldest]
                                           : trail_row[h][oldest] - row;
         span = 9 * dc * dc + 16 * dr * dr;
         if (span <= cfg.dist_limit) begin
            if (hold_count[h] < HOLD_MAX) hold_count[h]++;
         end else begin
            hold_count[h] = 0;
         end
         // top-left is tested first, so it wins when the corners overlap
         if (hold_count[h] > cfg.hold_frames && row < cfg.top_rows) begin
            if (col < cfg.left_cols) code = GEST_TOP_LEFT;
            else if (col > cfg.right_cols) code = GEST_TOP_RIGHT;
         end
      end
   endtask

   task automatic flag(input string field, input int unsigned want, input int unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t hdg_frame_checker: %s expected %0d actual %0d", $realtime, field, want, got);
   endtask

   always @(posedge clock) begin
      frame_verdict_type want;
      logic              l_in, r_in;
      logic [1:0]        lg, rg;
      if (reset) begin
         for (int h = 0; h < 2; h++) begin
            trail_fill[h] = 0;
            trail_head[h] = 0;
            hold_count[h] = 0;
         end
         cfg.dist_limit  = 23'd1474;
         cfg.hold_frames = 8'd30;
         cfg.top_rows    = 9'd48;
         cfg.left_cols   = 10'd64;
         cfg.right_cols  = 10'd576;
         awaited_verdicts.delete();
         outstanding <= 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_DIST_LIMIT:  cfg.dist_limit  = csr_wdata[DIST_W-1:0];
               CSR_HOLD_FRAMES: cfg.hold_frames = csr_wdata[HOLD_FR_W-1:0];
               CSR_TOP_ROWS:    cfg.top_rows    = csr_wdata[ROW_W-1:0];
               CSR_LEFT_COLS:   cfg.left_cols   = csr_wdata[COL_W-1:0];
               CSR_RIGHT_COLS:  cfg.right_cols  = csr_wdata[COL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            l_in = (req_lhand_row < req_spine_row) && (req_lhand_depth < req_spine_depth);
            r_in = (req_rhand_row < req_spine_row) && (req_rhand_depth < req_spine_depth);
            advance_trail(LEFT, req_lhand_col, req_lhand_row, l_in, lg);
            advance_trail(RIGHT, req_rhand_col, req_rhand_row, r_in, rg);
            want.left_in_range  = l_in;
            want.right_in_range = r_in;
            want.left_gesture   = lg;
            want.right_gesture  = rg;
            awaited_verdicts.insert(awaited_verdicts.size(), want);
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_verdicts.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t hdg_frame_checker: response beat with none outstanding",
                           $realtime);
            end else begin
               want = awaited_verdicts.pop_front();
               if (rsp_left_in_range !== want.left_in_range)
                  flag("left_in_range", want.left_in_range, rsp_left_in_range);
               if (rsp_right_in_range !== want.right_in_range)
                  flag("right_in_range", want.right_in_range, rsp_right_in_range);
               if (rsp_left_gesture !== want.left_gesture)
                  flag("left_gesture", want.left_gesture, rsp_left_gesture);
               if (rsp_right_gesture !== want.right_gesture)
                  flag("right_gesture", want.right_gesture, rsp_right_gesture);
            end
         end
         outstanding <= awaited_verdicts.size();
      end
   end

endmodule

// ----- tb/sv/tb_hand_dwell_gesture_detector_core.sv -----
// Top of the hand dwell gesture detector bench: clock, reset, frame stimulus, register
// phases and back-pressure. Depends on hdg_pkg, hdg_frame_checker and the core RTL.
`timescale 1ns / 1ps

module tb_hand_dwell_gesture_detector_core;

   import hdg_pkg::*;

   localparam int CYCLE_LIMIT     = 400000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int PHASES          = 7;
   localparam int SATURATE_PHASE  = 5;

   typedef struct packed {
      logic [COL_W-1:0]   spine_col;
      logic [ROW_W-1:0]   spine_row;
      logic [DEPTH_W-1:0] spine_depth;
      logic [COL_W-1:0]   lhand_col;
      logic [ROW_W-1:0]   lhand_row;
      logic [DEPTH_W-1:0] lhand_depth;
      logic [COL_W-1:0]   rhand_col;
      logic [ROW_W-1:0]   rhand_row;
      logic [DEPTH_W-1:0] rhand_depth;
   } skeleton_frame_type;

   typedef enum int {WALK_STILL, WALK_MOVE, WALK_AWAY, WALK_NOISE} walk_type;
   typedef enum int {DRAIN_FREE, DRAIN_HALF, DRAIN_SLOW} drain_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [COL_W-1:0]      req_spine_col = '0;
   logic [ROW_W-1:0]      req_spine_row = '0;
   logic [DEPTH_W-1:0]    req_spine_depth = '0;
   logic [COL_W-1:0]      req_lhand_col = '0;
   logic [ROW_W-1:0]      req_lhand_row = '0;
   logic [DEPTH_W-1:0]    req_lhand_depth = '0;
   logic [COL_W-1:0]      req_rhand_col = '0;
   logic [ROW_W-1:0]      req_rhand_row = '0;
   logic [DEPTH_W-1:0]    req_rhand_depth = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_left_in_range;
   logic                  rsp_right_in_range;
   logic [1:0]            rsp_left_gesture;
   logic [1:0]            rsp_right_gesture;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   int                    mismatches;
   int                    outstanding;

   int       cycle_count = 0;
   int       burst_left = 0;
   bit       hold_off_req = 1'b0;
   bit       hold_off_active = 1'b0;
   bit       long_hold = 1'b0;
   walk_type walk_mode [2];
   int       walk_left [2] = '{0, 0};
   int       walk_jit [2];
   int       anchor_col [2];
   int       anchor_row [2];

   // dist_limit, hold_frames, top_rows, left_cols, right_cols
   int unsigned phase_cfg [PHASES][5] = '{
      '{1474, 30, 48, 64, 576},
      '{8388607, 0, 511, 1023, 0},
      '{0, 255, 0, 0, 1023},
      '{225, 5, 60, 70, 560},
      '{1600, 12, 48, 64, 576},
      '{8388607, 255, 48, 64, 576},
      '{800, 2, 100, 200, 400}
   };
   // the saturation phase needs over a thousand still frames for the counter to top out
   int phase_items [PHASES] = '{30, 20, 15, 30, 30, 1060, 30};

   hand_dwell_gesture_detector_core DUT (.*);
   hdg_frame_checker u_checker (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic int clamp(input int v, input int hi);
      return (v < 0) ? 0 : (v > hi) ? hi : v;
   endfunction

   function automatic skeleton_frame_type frame(input int sc, sr, sd, lc, lr, ld, rc, rr, rd);
      skeleton_frame_type f;
      f.spine_col = sc; f.spine_row = sr; f.spine_depth = sd;
      f.lhand_col = lc; f.lhand_row = lr; f.lhand_depth = ld;
      f.rhand_col = rc; f.rhand_row = rr; f.rhand_depth = rd;
      return f;
   endfunction

   // Hold the beat until accepted; a new burst may open with an idle gap.
   task automatic send_frame(input skeleton_frame_type f);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (hold_off_active || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_spine_col   <= f.spine_col;
      req_spine_row   <= f.spine_row;
      req_spine_depth <= f.spine_depth;
      req_lhand_col   <= f.lhand_col;
      req_lhand_row   <= f.lhand_row;
      req_lhand_depth <= f.lhand_depth;
      req_rhand_col   <= f.rhand_col;
      req_rhand_row   <= f.rhand_row;
      req_rhand_depth <= f.rhand_depth;
      do @(posedge clock); while (!req_ready);
   endtask

   // Drop valid and wait for every outstanding response beat.
   task automatic drain_frames();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   // Narrow registers get random junk above their width.
   task automatic program_regs(input int unsigned dl, hf, tr, lc, rc);
      logic [CSR_IDX_W-1:0]  regs [5];
      logic [CSR_DATA_W-1:0] vals [5];
      regs[0] = CSR_DIST_LIMIT;
      regs[1] = CSR_HOLD_FRAMES;
      regs[2] = CSR_TOP_ROWS;
      regs[3] = CSR_LEFT_COLS;
      regs[4] = CSR_RIGHT_COLS;
      vals[0] = CSR_DATA_W'(dl);
      vals[1] = CSR_DATA_W'({$urandom(), hf[HOLD_FR_W-1:0]});
      vals[2] = CSR_DATA_W'({$urandom(), tr[ROW_W-1:0]});
      vals[3] = CSR_DATA_W'({$urandom(), lc[COL_W-1:0]});
      vals[4] = CSR_DATA_W'({$urandom(), rc[COL_W-1:0]});
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_index <= regs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Mostly hands dwelling near a corner anchor, with moves, retreats and noise between.
   task automatic next_frame(output skeleton_frame_type f);
      int    pick, c, r, d, sd;
      int    hc [2];
      int    hr [2];
      int    hd [2];
      f.spine_col = $urandom_range(0, 1023);
      if (!long_hold && $urandom_range(0, 31) == 0) begin
         f.spine_row   = $urandom_range(0, 511);
         f.spine_depth = $urandom_range(0, 8191);
      end else begin
         f.spine_row   = $urandom_range(380, 511);
         f.spine_depth = $urandom_range(2600, 8191);
      end
      sd = f.spine_depth;
      for (int h = 0; h < 2; h++) begin
         if (walk_left[h] == 0) begin
            pick = $urandom_range(0, 9);
            walk_mode[h] = (long_hold || pick < 6) ? WALK_STILL :
                           (pick < 8) ? WALK_MOVE : (pick < 9) ? WALK_AWAY : WALK_NOISE;
            walk_left[h] = (walk_mode[h] == WALK_STILL) ? $urandom_range(5, 60)
                                                        : $urandom_range(1, 8);
            walk_jit[h] = $urandom_range(0, 6);
            pick = long_hold ? h : $urandom_range(0, 2);
            anchor_row[h] = $urandom_range(0, 60);
            case (pick)
               0: anchor_col[h] = $urandom_range(0, 70);
               1: anchor_col[h] = $urandom_range(560, 639);
               default: begin
                  anchor_col[h] = $urandom_range(0, 639);
                  anchor_row[h] = $urandom_range(0, 300);
               end
            endcase
            if (long_hold) begin
               walk_left[h] = 1 << 20;
               walk_jit[h]  = 2;
               anchor_col[h] = h ? $urandom_range(590, 630) : $urandom_range(10, 50);
               anchor_row[h] = $urandom_range(5, 40);
            end
         end
         walk_left[h]--;
         d = clamp(sd - $urandom_range(1, 2500), 8191);
         case (walk_mode[h])
            WALK_MOVE: begin
               anchor_col[h] = clamp(anchor_col[h] + $urandom_range(0, 120) - 60, 1023);
               anchor_row[h] = clamp(anchor_row[h] + $urandom_range(0, 120) - 60, 511);
               c = anchor_col[h];
               r = anchor_row[h];
            end
            WALK_NOISE: begin
               c = $urandom_range(0, 1023);
               r = $urandom_range(0, 511);
               d = $urandom_range(0, 8191);
            end
            default: begin
               c = clamp(anchor_col[h] + $urandom_range(0, 2 * walk_jit[h]) - walk_jit[h], 1023);
               r = clamp(anchor_row[h] + $urandom_range(0, 2 * walk_jit[h]) - walk_jit[h], 511);
               // retreat behind the spine plane
               if (walk_mode[h] == WALK_AWAY) d = clamp(sd + $urandom_range(0, 500), 8191);
            end
         endcase
         hc[h] = c;
         hr[h] = r;
         hd[h] = d;
      end
      f.lhand_col = hc[0]; f.lhand_row = hr[0]; f.lhand_depth = hd[0];
      f.rhand_col = hc[1]; f.rhand_row = hr[1]; f.rhand_depth = hd[1];
   endtask

   // Response side: stall pattern in segments, plus long hold-offs on request.
   initial begin
      drain_type mode;
      int        seg;
      forever begin
         mode = drain_type'($urandom_range(0, 2));
         seg  = $urandom_range(4, 60);
         repeat (seg) begin
            @(posedge clock);
            if (hold_off_req) begin
               hold_off_req    = 1'b0;
               hold_off_active = 1'b1;
               rsp_ready <= 1'b0;
               repeat (HOLD_OFF_CYCLES) @(posedge clock);
               hold_off_active = 1'b0;
            end else begin
               case (mode)
                  DRAIN_FREE: rsp_ready <= 1'b1;
                  DRAIN_HALF: rsp_ready <= $urandom_range(0, 1);
                  default:    rsp_ready <= ($urandom_range(0, 3) == 0);
               endcase
            end
         end
      end
   end

   initial begin
      skeleton_frame_type f;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: first frame sees zero distance, then both field extremes
      send_frame(frame(100, 320, 5000, 10, 10, 1000, 630, 10, 1000));
      send_frame(frame(0, 0, 0, 0, 0, 0, 0, 0, 0));
      send_frame(frame(1023, 511, 8191, 1023, 511, 8191, 1023, 511, 8191));
      drain_frames();

      // motion up to the largest distance limit counts as still and one frame is enough: corner edges
      program_regs(8388607, 0, 48, 64, 576);
      send_frame(frame(5, 320, 5000, 10, 10, 1000, 630, 10, 1000));
      send_frame(frame(700, 320, 5000, 64, 10, 1000, 576, 10, 1000));
      send_frame(frame(20, 320, 5000, 63, 47, 1000, 577, 47, 1000));
      send_frame(frame(1000, 320, 5000, 10, 48, 1000, 630, 48, 1000));
      send_frame(frame(320, 320, 5000, 10, 320, 1000, 630, 10, 5000));
      send_frame(frame(320, 320, 5000, 10, 319, 4999, 630, 319, 4999));
      send_frame(frame(512, 511, 8191, 1023, 0, 0, 0, 0, 0));
      drain_frames();

      // zero distance limit: only an exact return to the oldest point counts
      program_regs(0, 0, 48, 64, 576);
      send_frame(frame(33, 320, 5000, 10, 10, 1000, 630, 10, 1000));
      send_frame(frame(33, 320, 5000, 11, 10, 1000, 630, 11, 1000));
      send_frame(frame(33, 320, 5000, 10, 10, 1000, 630, 10, 1000));

      for (int p = 0; p < PHASES; p++) begin
         drain_frames();
         program_regs(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                      phase_cfg[p][3], phase_cfg[p][4]);
         long_hold    = (p == SATURATE_PHASE);
         walk_left[0] = 0;
         walk_left[1] = 0;
         if (p == 0 || p == PHASES - 1) hold_off_req = 1'b1;
         for (int n = 0; n < phase_items[p]; n++) begin
            next_frame(f);
            send_frame(f);
         end
      end
      drain_frames();
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
